/* design/scchs_pkg.sv */
// Package for the SCC Hamiltonian shift block: operation codes, widths, saturation helper.
`timescale 1ns / 1ps
`default_nettype none

package scchs_pkg;

    // Operation carried in the low bits of the slave tuser.
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_GAMMA  = 2'd1,
        OP_MATRIX = 2'd2
    } op_t;

    localparam int OP_W    = 2;
    localparam int ATOM_W  = 8;
    localparam int VAL_W   = 32;
    localparam int WIDE_W  = 65;
    localparam int PROD_W  = 64;

    localparam int DEFAULT_MAX_ATOMS = 256;
    localparam int DEFAULT_FRAC_BITS = 24;

    typedef struct packed {
        logic             clip;
        logic [VAL_W-1:0] value;
    } sat_res_t;

    // Clip a wide signed value to the 32-bit range.
    function automatic sat_res_t sat32(input logic signed [WIDE_W-1:0] x);
        sat_res_t res;
        if (x > 65'sd2147483647) begin
            res.clip  = 1'b1;
            res.value = 32'h7fff_ffff;
        end else if (x < -65'sd2147483648) begin
            res.clip  = 1'b1;
            res.value = 32'h8000_0000;
        end else begin
            res.clip  = 1'b0;
            res.value = x[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/scchs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module scchs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // a read at the address being written returns the old word
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/scc_hamiltonian_shift_top.sv */
// Top level of the SCC Hamiltonian shift block: stores, pipeline and output skid.
`timescale 1ns / 1ps
`default_nettype none

// The block applies the self-consistent-charge shift to tight-binding matrix
// elements. Three kinds of item arrive on the slave stream: a charge item stores
// the charge fluctuation of one atom, a gamma item adds round(gamma * dq(C)) into
// the potential V(A) (first_term restarts the sum), and a matrix item returns
// H0 - 0.5 * S * (V(A) + V(B)) rounded half up and clipped to 32 bits, with the
// clip reported in m_tuser. Only matrix items produce an output item. Values
// are signed fixed point with FRAC_BITS fraction bits (Q8.24 by default); atom
// indices wrap modulo MAX_ATOMS. The block takes one item per cycle unless it
// halts; a matrix result passes the stage and output registers on its way to
// m_tvalid. The rate is set by the single write port of the potential store:
// each gamma item writes its sum back in the third pipeline stage, and the last
// three write-backs are forwarded so a gamma or matrix item right behind a gamma
// item on the same atom sees the new potential. A two-entry output register and
// skid stage keep the slave side open while one result waits; the pipeline
// halts only when both are full. Both stores are uninitialized: read an atom's
// charge or potential only after writing it. No clearing pass follows reset.

module scc_hamiltonian_shift_top #(
    parameter int MAX_ATOMS = scchs_pkg::DEFAULT_MAX_ATOMS,
    parameter int FRAC_BITS = scchs_pkg::DEFAULT_FRAC_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] atom_first, [15:8] atom_second, [47:16] value_main,
    // [79:48] overlap_value
    input  wire logic [79:0] s_tdata,
    // [1:0] operation, [2] first_term
    input  wire logic [2:0]  s_tuser,
    // master stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] corrected_value
    output logic [31:0]      m_tdata,
    // [0] saturated
    output logic [0:0]       m_tuser
);

    localparam int AW       = $clog2(MAX_ATOMS);
    localparam int VW       = scchs_pkg::VAL_W;
    localparam int PW       = scchs_pkg::PROD_W;
    localparam int WW       = scchs_pkg::WIDE_W;
    localparam int CORR_W   = WW - (FRAC_BITS + 1);
    localparam int HIST     = 3;
    localparam int SLOT_CNT = 1 << scchs_pkg::ATOM_W;

    localparam logic signed [PW-1:0] GAM_RND  = PW'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [WW-1:0] CORR_RND = WW'(65'sd1 <<< FRAC_BITS);

    typedef struct packed {
        logic          vld;
        logic [AW-1:0] addr;
        logic [VW-1:0] data;
    } wr_rec_t;

    // ---------------------------------------------------------------- input
    logic                        adv;
    logic                        accept;
    logic [scchs_pkg::OP_W-1:0]  in_op;
    logic [scchs_pkg::ATOM_W-1:0] in_atom_first;
    logic [scchs_pkg::ATOM_W-1:0] in_atom_second;
    logic                        in_first;
    logic [VW-1:0]               in_vmain;
    logic [VW-1:0]               in_sval;
    logic [AW-1:0]               slot_a;
    logic [AW-1:0]               slot_b;
    logic [AW-1:0]               slot_lut [SLOT_CNT];

    assign in_op          = s_tuser[1:0];
    assign in_first       = s_tuser[2];
    assign in_atom_first  = s_tdata[7:0];
    assign in_atom_second = s_tdata[15:8];
    assign in_vmain       = s_tdata[47:16];
    assign in_sval        = s_tdata[79:48];

    // Atom index to store slot, wrapping modulo MAX_ATOMS; constant table.
    for (genvar g = 0; g < SLOT_CNT; g++)
    begin : g_slot
        assign slot_lut[g] = AW'(g % MAX_ATOMS);
    end

    assign slot_a = slot_lut[in_atom_first];
    assign slot_b = slot_lut[in_atom_second];

    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // ---------------------------------------------------------------- stores
    logic [VW-1:0] chg_rdata;
    logic [VW-1:0] pot_a_rdata;
    logic [VW-1:0] pot_b_rdata;
    logic          chg_we;
    logic          pot_we;
    logic [AW-1:0] pot_waddr;
    logic [VW-1:0] pot_wdata;

    assign chg_we = accept && (in_op == scchs_pkg::OP_LOAD);

    scchs_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ATOMS)
    ) u_charge_ram (
        .clk   (clk),
        .we    (chg_we),
        .waddr (slot_a),
        .wdata (in_vmain),
        .re    (accept),
        .raddr (slot_b),
        .rdata (chg_rdata)
    );

    // Two copies of the potential store, written alike, give two read ports.
    scchs_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ATOMS)
    ) u_pot_a_ram (
        .clk   (clk),
        .we    (pot_we),
        .waddr (pot_waddr),
        .wdata (pot_wdata),
        .re    (accept),
        .raddr (slot_a),
        .rdata (pot_a_rdata)
    );

    scchs_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_ATOMS)
    ) u_pot_b_ram (
        .clk   (clk),
        .we    (pot_we),
        .waddr (pot_waddr),
        .wdata (pot_wdata),
        .re    (accept),
        .raddr (slot_b),
        .rdata (pot_b_rdata)
    );

    // ---------------------------------------------------------------- stage 1
    // Item registers; store read data lines up with them.
    logic                 s1_gam_reg;
    logic                 s1_mat_reg;
    logic [AW-1:0]        s1_a_reg;
    logic [AW-1:0]        s1_b_reg;
    logic                 s1_first_reg;
    logic signed [VW-1:0] s1_vmain_reg;
    logic signed [VW-1:0] s1_sval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_gam_reg <= 1'b0;
            s1_mat_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_gam_reg <= accept && (in_op == scchs_pkg::OP_GAMMA);
            s1_mat_reg <= accept && (in_op == scchs_pkg::OP_MATRIX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_a_reg     <= slot_a;
            s1_b_reg     <= slot_b;
            s1_first_reg <= in_first;
            s1_vmain_reg <= in_vmain;
            s1_sval_reg  <= in_sval;
        end
    end

    // gamma * dq, exact
    logic signed [PW-1:0] s2_prod_next;
    assign s2_prod_next = PW'(s1_vmain_reg) * PW'($signed(chg_rdata));

    // ---------------------------------------------------------------- stage 2
    logic                 s2_gam_reg;
    logic                 s2_mat_reg;
    logic [AW-1:0]        s2_a_reg;
    logic [AW-1:0]        s2_b_reg;
    logic                 s2_first_reg;
    logic signed [PW-1:0] s2_prod_reg;
    logic signed [VW-1:0] s2_h0_reg;
    logic signed [VW-1:0] s2_sval_reg;
    logic signed [VW-1:0] s2_va_reg;
    logic signed [VW-1:0] s2_vb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_gam_reg <= 1'b0;
            s2_mat_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_gam_reg <= s1_gam_reg;
            s2_mat_reg <= s1_mat_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_a_reg     <= s1_a_reg;
            s2_b_reg     <= s1_b_reg;
            s2_first_reg <= s1_first_reg;
            s2_prod_reg  <= s2_prod_next;
            s2_h0_reg    <= s1_vmain_reg;
            s2_sval_reg  <= s1_sval_reg;
            s2_va_reg    <= pot_a_rdata;
            s2_vb_reg    <= pot_b_rdata;
        end
    end

    // Round the product half up to FRAC_BITS and clip it.
    logic signed [PW-1:0] gam_rnd_sum;
    logic signed [PW-1:0] gam_rnd;
    scchs_pkg::sat_res_t  s3_term_next;

    assign gam_rnd_sum  = s2_prod_reg + GAM_RND;
    assign gam_rnd      = gam_rnd_sum >>> FRAC_BITS;
    assign s3_term_next = scchs_pkg::sat32(WW'(gam_rnd));

    // ---------------------------------------------------------------- stage 3
    logic                 s3_gam_reg;
    logic                 s3_mat_reg;
    logic [AW-1:0]        s3_a_reg;
    logic [AW-1:0]        s3_b_reg;
    logic                 s3_first_reg;
    logic signed [VW-1:0] s3_term_reg;
    logic signed [VW-1:0] s3_h0_reg;
    logic signed [VW-1:0] s3_sval_reg;
    logic signed [VW-1:0] s3_va_reg;
    logic signed [VW-1:0] s3_vb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_gam_reg <= 1'b0;
            s3_mat_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_gam_reg <= s2_gam_reg;
            s3_mat_reg <= s2_mat_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_a_reg     <= s2_a_reg;
            s3_b_reg     <= s2_b_reg;
            s3_first_reg <= s2_first_reg;
            s3_term_reg  <= s3_term_next.value;
            s3_h0_reg    <= s2_h0_reg;
            s3_sval_reg  <= s2_sval_reg;
            s3_va_reg    <= s2_va_reg;
            s3_vb_reg    <= s2_vb_reg;
        end
    end

    // Write-back history: entry 0 is the newest. The store read of this item
    // missed exactly these three write-backs.
    wr_rec_t              hist_reg [HIST];
    logic signed [VW-1:0] vcur_a;
    logic signed [VW-1:0] vcur_b;

    always_comb
    begin
        vcur_a = s3_va_reg;
        vcur_b = s3_vb_reg;
        // oldest first so the newest match wins
        for (int i = HIST - 1; i >= 0; i--)
        begin
            if (hist_reg[i].vld && (hist_reg[i].addr == s3_a_reg))
            begin
                vcur_a = hist_reg[i].data;
            end
            if (hist_reg[i].vld && (hist_reg[i].addr == s3_b_reg))
            begin
                vcur_b = hist_reg[i].data;
            end
        end
    end

    logic signed [WW-1:0] acc_wide;
    scchs_pkg::sat_res_t  acc_sat;

    assign acc_wide  = WW'(s3_term_reg) + WW'(vcur_a);
    assign acc_sat   = scchs_pkg::sat32(acc_wide);
    assign pot_we    = adv && s3_gam_reg;
    assign pot_waddr = s3_a_reg;
    assign pot_wdata = s3_first_reg ? s3_term_reg : acc_sat.value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            hist_reg[0] <= '{vld: s3_gam_reg, addr: s3_a_reg, data: pot_wdata};
            for (int i = 1; i < HIST; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    logic signed [PW-1:0] s4_p0_next;
    logic signed [PW-1:0] s4_p1_next;

    assign s4_p0_next = PW'(s3_sval_reg) * PW'(vcur_a);
    assign s4_p1_next = PW'(s3_sval_reg) * PW'(vcur_b);

    // ---------------------------------------------------------------- stage 4
    logic                 s4_mat_reg;
    logic signed [PW-1:0] s4_p0_reg;
    logic signed [PW-1:0] s4_p1_reg;
    logic signed [VW-1:0] s4_h0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_mat_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_mat_reg <= s3_mat_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_p0_reg <= s4_p0_next;
            s4_p1_reg <= s4_p1_next;
            s4_h0_reg <= s3_h0_reg;
        end
    end

    // 0.5 * S * (V(A) + V(B)), rounded half up: one extra bit of shift.
    logic signed [WW-1:0]     corr_sum;
    logic signed [WW-1:0]     corr_full;
    logic signed [CORR_W-1:0] s5_corr_next;

    assign corr_sum     = WW'(s4_p0_reg) + WW'(s4_p1_reg) + CORR_RND;
    assign corr_full    = corr_sum >>> (FRAC_BITS + 1);
    assign s5_corr_next = corr_full[CORR_W-1:0];

    // ---------------------------------------------------------------- stage 5
    logic                     s5_mat_reg;
    logic signed [CORR_W-1:0] s5_corr_reg;
    logic signed [VW-1:0]     s5_h0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_mat_reg <= 1'b0;
        end
        else if (adv)
        begin
            s5_mat_reg <= s4_mat_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_corr_reg <= s5_corr_next;
            s5_h0_reg   <= s4_h0_reg;
        end
    end

    logic signed [WW-1:0] res_wide;
    scchs_pkg::sat_res_t  res_sat;
    logic                 load;

    assign res_wide = WW'(s5_h0_reg) - WW'(s5_corr_reg);
    assign res_sat  = scchs_pkg::sat32(res_wide);
    assign load     = adv && s5_mat_reg;

    // ---------------------------------------------------------------- output
    // Output register plus one skid entry; the pipeline halts only when the
    // skid entry is occupied.
    logic                out_valid_reg;
    logic                skid_valid_reg;
    scchs_pkg::sat_res_t out_reg;
    scchs_pkg::sat_res_t skid_reg;

    assign adv = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= load;
            end
        end
        else if (load)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res_sat;
        end
        else if (load)
        begin
            skid_reg <= res_sat;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.value;
    assign m_tuser[0] = out_reg.clip;

`ifndef SYNTHESIS
    // the skid entry fills only behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(m_tvalid && !m_tready))
        else $error("skid entry filled while output was free");

    a_result_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> m_tvalid)
        else $error("matrix result lost at output stage");

    a_hist_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(hist_reg[0]))
        else $error("write-back history moved while pipeline halted");
`endif

endmodule

`default_nettype wire

/* test/tb_scc_hamiltonian_shift_top.sv */
// Self-checking testbench for the SCC Hamiltonian shift block.
`timescale 1ns / 1ps

module tb_scc_hamiltonian_shift_top;

    // Fraction bits of the Q8.24 format and the rounding constants that go with them.
    localparam int     FRAC       = scchs_pkg::DEFAULT_FRAC_BITS;
    localparam int     VW         = scchs_pkg::VAL_W;
    localparam longint ROUND_HALF = longint'(1) << (FRAC - 1);
    localparam longint ROUND_ONE  = longint'(1) << FRAC;
    localparam longint Q_MAX      = 64'sd2147483647;
    localparam longint Q_MIN      = -64'sd2147483648;
    localparam int     ONE_Q      = 32'sh0100_0000;

    // Code 3 is not in the package enum; the block must drop it silently.
    localparam logic [scchs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // Cycles a result may still be in flight after the last one came out.
    localparam int DRAIN_CYCLES = 10;
    localparam int NUM_RANDOM   = 490;
    localparam int QUIET_ITEMS  = 80;

    typedef struct {
        logic [VW-1:0] value;
        logic          clip;
    } h_elem_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    // Shadow of the block's charge and potential stores.
    int  dq_mem  [256];
    int  pot_mem [256];
    bit  dq_written  [256];
    bit  pot_written [256];
    byte unsigned charged_atoms[$];
    byte unsigned potential_atoms[$];
    byte unsigned last_atom = 8'd0;

    // Corrected matrix elements still owed by the block, oldest first.
    h_elem_t expected_h_q[$];

    int error_count = 0;
    bit quiet       = 1'b0;
    int hold_left   = 0;

    scc_hamiltonian_shift_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clip a wide value to 32 bits; flag the clip.
    function automatic longint clip32(input longint x, inout bit clip);
        if (x > Q_MAX)
        begin
            clip = 1'b1;
            return Q_MAX;
        end
        if (x < Q_MIN)
        begin
            clip = 1'b1;
            return Q_MIN;
        end
        return x;
    endfunction

    // Apply one accepted item to the shadow stores; queue the corrected element
    // for a matrix item.
    function automatic void predict_shift(input logic [scchs_pkg::OP_W-1:0] op,
                                          input byte unsigned a, input byte unsigned b,
                                          input bit first, input int vmain, input int s);
        longint  prod;
        longint  acc;
        longint  p1;
        longint  p2;
        longint  half;
        longint  corr;
        bit      clip;
        h_elem_t res;
        clip = 1'b0;
        case (op)
            scchs_pkg::OP_LOAD:
            begin
                dq_mem[a] = vmain;
                if (!dq_written[a])
                begin
                    dq_written[a] = 1'b1;
                    charged_atoms = {charged_atoms, a};
                end
            end
            scchs_pkg::OP_GAMMA:
            begin
                prod = longint'(vmain) * longint'(dq_mem[b]);
                acc  = clip32((prod + ROUND_HALF) >>> FRAC, clip);
                if (!first)
                    acc = clip32(acc + longint'(pot_mem[a]), clip);
                pot_mem[a] = int'(acc);
                if (!pot_written[a])
                begin
                    pot_written[a] = 1'b1;
                    potential_atoms = {potential_atoms, a};
                end
            end
            scchs_pkg::OP_MATRIX:
            begin
                p1   = longint'(s) * longint'(pot_mem[a]);
                p2   = longint'(s) * longint'(pot_mem[b]);
                // floor((p1 + p2) / 2) without a 65-bit sum
                half = (p1 >>> 1) + (p2 >>> 1) + ((p1 & p2) & longint'(1));
                corr = (half + ROUND_HALF) >>> FRAC;
                res.value = VW'(clip32(longint'(vmain) - corr, clip));
                res.clip  = clip;
                expected_h_q = {expected_h_q, res};
            end
            default: ;
        endcase
    endfunction

    // Mostly small values so sums stay in range, with full-range and extreme values mixed in.
    function automatic int rand_q824();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
            6, 7:             return int'($urandom());
            8:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh7fff_ffff;
                    1:       return 32'sh8000_0000;
                    2:       return 0;
                    3:       return 1;
                    default: return -1;
                endcase
            end
            default:          return int'($urandom()) >>> $urandom_range(0, 31);
        endcase
    endfunction

    // Offer one item, hold it until accepted, then update the prediction.
    // Leave s_tvalid high on return; a drain or a gap in the next call lowers it.
    task automatic send_item(input logic [scchs_pkg::OP_W-1:0] op, input byte unsigned a,
                             input byte unsigned b, input bit first,
                             input int vmain, input int s);
        if (!quiet && $urandom_range(0, 99) < 14)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {s, vmain, b, a};
        s_tuser  <= {first, op};
        do
            @(posedge clk);
        while (!s_tready);
        predict_shift(op, a, b, first, vmain, s);
    endtask

    // Stop offering and wait until every corrected element has come back,
    // then let the pipeline settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_h_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_load();
        byte unsigned a;
        a = ($urandom_range(0, 3) == 0) ? last_atom : 8'($urandom());
        last_atom = a;
        send_item(scchs_pkg::OP_LOAD, a, 8'($urandom()), 1'($urandom()), rand_q824(),
                  int'($urandom()));
    endtask

    // Gamma term: column atom always charged; row atom starts a new sum if its
    // potential holds nothing, else one time in four.
    task automatic send_random_gamma();
        byte unsigned a;
        byte unsigned b;
        bit           first;
        int           pick;
        b    = charged_atoms[$urandom_range(0, charged_atoms.size() - 1)];
        pick = $urandom_range(0, 9);
        if (pick < 5 && potential_atoms.size() != 0)
            a = potential_atoms[$urandom_range(0, potential_atoms.size() - 1)];
        else if (pick < 7)
            a = last_atom;
        else
            a = 8'($urandom());
        first = pot_written[a] ? ($urandom_range(0, 3) == 0) : 1'b1;
        last_atom = a;
        send_item(scchs_pkg::OP_GAMMA, a, b, first, rand_q824(), int'($urandom()));
    endtask

    // Matrix element: both atoms must already have a potential.
    task automatic send_random_matrix();
        byte unsigned a;
        byte unsigned b;
        a = potential_atoms[$urandom_range(0, potential_atoms.size() - 1)];
        b = potential_atoms[$urandom_range(0, potential_atoms.size() - 1)];
        if (pot_written[last_atom] && $urandom_range(0, 2) == 0)
            a = last_atom;
        last_atom = b;
        send_item(scchs_pkg::OP_MATRIX, a, b, 1'($urandom()), rand_q824(), rand_q824());
    endtask

    // Extremes of every field, both rounding directions, clipping of products,
    // sums and results, the unused code, and back-to-back updates of one atom.
    task automatic test_directed();
        send_item(scchs_pkg::OP_LOAD, 8'd0,   8'hAA, 1'b1, 32'sh8000_0000, int'($urandom()));
        send_item(scchs_pkg::OP_LOAD, 8'd255, 8'hFF, 1'b0, 32'sh7fff_ffff, int'($urandom()));
        send_item(scchs_pkg::OP_LOAD, 8'd1,   8'h00, 1'b0, ONE_Q,          int'($urandom()));
        send_item(scchs_pkg::OP_LOAD, 8'd2,   8'h55, 1'b1, -ONE_Q,         int'($urandom()));
        send_item(scchs_pkg::OP_LOAD, 8'd4,   8'h01, 1'b0, 1,              int'($urandom()));
        // V(0) = 2.0, then subtract 0.5 right behind it
        send_item(scchs_pkg::OP_GAMMA, 8'd0, 8'd1, 1'b1, 2 * ONE_Q, 32'hffff_ffff);
        send_item(scchs_pkg::OP_GAMMA, 8'd0, 8'd2, 1'b0, ONE_Q / 2, 32'h0);
        // product clips high, then the sum clips high
        send_item(scchs_pkg::OP_GAMMA, 8'd255, 8'd255, 1'b1, 32'sh7fff_ffff, int'($urandom()));
        send_item(scchs_pkg::OP_GAMMA, 8'd255, 8'd255, 1'b0, 32'sh7fff_ffff, int'($urandom()));
        // product clips high, then a product clipped low brings the sum to -1
        send_item(scchs_pkg::OP_GAMMA, 8'd128, 8'd0,   1'b1, 32'sh8000_0000, int'($urandom()));
        send_item(scchs_pkg::OP_GAMMA, 8'd128, 8'd255, 1'b0, 32'sh8000_0000, int'($urandom()));
        // exact half rounds up, negative half rounds to zero
        send_item(scchs_pkg::OP_GAMMA, 8'd4, 8'd4, 1'b1, 32'sh0080_0000,  int'($urandom()));
        send_item(scchs_pkg::OP_GAMMA, 8'd5, 8'd4, 1'b1, -32'sh0080_0000, int'($urandom()));
        send_item(scchs_pkg::OP_MATRIX, 8'd0,   8'd0,   1'b0, 0,              ONE_Q);
        send_item(scchs_pkg::OP_MATRIX, 8'd255, 8'd255, 1'b1, 32'sh8000_0000, 32'sh7fff_ffff);
        send_item(scchs_pkg::OP_MATRIX, 8'd255, 8'd128, 1'b0, 32'sh7fff_ffff, 32'sh8000_0000);
        send_item(scchs_pkg::OP_MATRIX, 8'd4,   8'd5,   1'b1, 5,              ONE_Q);
        send_item(scchs_pkg::OP_MATRIX, 8'd128, 8'd0,   1'b0, ONE_Q,          -ONE_Q);
        send_item(scchs_pkg::OP_MATRIX, 8'd5,   8'd128, 1'b1, 32'sh8000_0000, 0);
        // unused code must neither answer nor touch the stores
        send_item(OP_UNUSED, 8'($urandom()), 8'($urandom()), 1'($urandom()),
                  int'($urandom()), int'($urandom()));
        send_item(OP_UNUSED, 8'hFF, 8'hFF, 1'b1, -1, -1);
        send_item(scchs_pkg::OP_MATRIX, 8'd0, 8'd255, 1'b0, rand_q824(), rand_q824());
        drain_results();
    endtask

    // Hold the receiver off for a long stretch while items keep coming, so the
    // output buffer fills and the block must stall its input.
    task automatic test_backpressure();
        quiet     <= 1'b1;
        hold_left <= 60;
        repeat (4) send_random_gamma();
        repeat (30) send_random_matrix();
        quiet <= 1'b0;
        drain_results();
    endtask

    // Mostly well-formed streams with random content; a few unused codes as noise.
    // Open with a stretch where neither side idles.
    task automatic test_random_stream();
        int pick;
        quiet <= 1'b1;
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == QUIET_ITEMS)
                quiet <= 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_item(OP_UNUSED, 8'($urandom()), 8'($urandom()), 1'($urandom()),
                          int'($urandom()), int'($urandom()));
            else if (pick < 24)
                send_random_load();
            else if (pick < 60)
                send_random_gamma();
            else
                send_random_matrix();
        end
        drain_results();
    endtask

    // Receiver: count down a requested hold-off, otherwise stall at random
    // unless the no-idle stretch is on.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (quiet)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 14);
        end
    end

    // Compare every accepted result with the oldest corrected element owed.
    always @(posedge clk)
    begin : check_results
        h_elem_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_h_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: value %h sat %0b", m_tdata, m_tuser[0]);
            end
            else
            begin
                want = expected_h_q.pop_front();
                if (m_tdata !== want.value || m_tuser[0] !== want.clip)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected value %h sat %0b, got value %h sat %0b",
                                 want.value, want.clip, m_tdata, m_tuser[0]);
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_stream();

        if (error_count == 0 && expected_h_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* scc_hamiltonian_shift_top.f */
design/scchs_pkg.sv
design/scchs_ram.sv
design/scc_hamiltonian_shift_top.sv
test/tb_scc_hamiltonian_shift_top.sv
